// ===== hw/rtl/ucb1_arm_selector_defines.svh =====
// Assertion macros shared by the RTL of the arm selector.
`ifndef UCB1_ARM_SELECTOR_DEFINES_SVH
`define UCB1_ARM_SELECTOR_DEFINES_SVH

// Implication checked at every clock edge while out of reset.
`define UCB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked while out of reset.
`define UCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/ucb_pkg.sv =====
// ----------------------------------------------------------------------------
// ucb_pkg
// Shared constants and types of the UCB1 arm selector.
// ----------------------------------------------------------------------------
package ucb_pkg;
    localparam int ARM_COUNT_DEF   = 8;
    localparam int COUNT_WIDTH_DEF = 24;
    localparam int TOTAL_WIDTH     = 30;
    localparam int ARMS_RESET      = 8;
    localparam int LN_W            = 22;   // Q6.16 ln, below 2^22
    localparam int VAL_W           = 22;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;
endpackage

// ===== hw/rtl/ucb_div.sv =====
// ----------------------------------------------------------------------------
// ucb_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ucb_div #(
    parameter int NW = 48,
    parameter int DW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_quo;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW+1:0] w_try;

    assign w_try = {r_rem, r_quo[NW-1]} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
            r_quo  <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            // The remainder always stays below the divisor.
            if (!w_try[DW+1]) begin
                r_rem <= w_try[DW:0];
                r_quo <= {r_quo[NW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DW-1:0], r_quo[NW-1]};
                r_quo <= {r_quo[NW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
endmodule

// ===== hw/rtl/ucb_ln.sv =====
// ----------------------------------------------------------------------------
// ucb_ln
// Natural log in Q6.16 by leading-one search and repeated squaring.
// ----------------------------------------------------------------------------
module ucb_ln (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ucb_pkg::TOTAL_WIDTH-1:0] i_x,
    output logic                         o_busy,
    output logic [ucb_pkg::LN_W-1:0]     o_ln
);
    localparam int LN_BITS = ucb_pkg::LN_W;
    typedef enum logic [1:0] {S_IDLE, S_NORM, S_SQ, S_MUL} t_state;
    t_state      r_state;
    logic [31:0] r_m;
    logic [4:0]  r_msb;
    logic [15:0] r_frac;
    logic [4:0]  r_k;
    logic [LN_BITS-1:0] r_ln;
    logic [63:0] w_sq;
    logic [32:0] w_m;
    logic [52:0] w_prod;

    assign w_sq   = {32'd0, r_m} * {32'd0, r_m};
    assign w_m    = w_sq[63:31];
    assign w_prod = {r_msb, r_frac} * ucb_pkg::LN2_Q32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_m     <= {2'b00, i_x};
                        // A zero input skips straight to a zero product.
                        r_msb   <= (i_x == '0) ? 5'd0 : 5'd29;
                        r_frac  <= '0;
                        r_k     <= '0;
                        r_state <= (i_x == '0) ? S_MUL : S_NORM;
                    end
                end
                S_NORM: begin
                    // Shift left one place a cycle until the leading one is at bit 29, then two places to bit 31.
                    if (r_m[29]) begin
                        r_m     <= {r_m[29:0], 2'b00};
                        r_state <= S_SQ;
                    end else begin
                        r_m   <= {r_m[30:0], 1'b0};
                        r_msb <= r_msb - 1'b1;
                    end
                end
                S_SQ: begin
                    r_m    <= w_m[32] ? w_m[32:1] : w_m[31:0];
                    r_frac <= {r_frac[14:0], w_m[32]};
                    r_k    <= r_k + 1'b1;
                    if (r_k == 5'd15) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_ln    <= w_prod[32 +: LN_BITS];
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_ln   = r_ln;
endmodule

// ===== hw/rtl/ucb_sqrt.sv =====
// ----------------------------------------------------------------------------
// ucb_sqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ucb_sqrt #(
    parameter int VW = 40
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [VW-1:0] i_v,
    output logic          o_busy,
    output logic [VW/2-1:0] o_root
);
    localparam int HW = (VW + 1) / 2;
    localparam int PW = 2 * HW;
    localparam int CW = $clog2(HW + 1);
    logic [PW-1:0] r_v;
    logic [HW+1:0] r_rem;
    logic [HW-1:0] r_res;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [HW+1:0] w_cur;
    logic [HW+1:0] w_trial;
    logic [HW+2:0] w_diff;

    assign w_cur   = {r_rem[HW-1:0], r_v[PW-1 -: 2]};
    assign w_trial = {r_res, 2'b01};
    assign w_diff  = {1'b0, w_cur} - {1'b0, w_trial};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(HW);
            r_v    <= PW'(i_v);
            r_rem  <= '0;
            r_res  <= '0;
        end else if (r_busy) begin
            r_v <= {r_v[PW-3:0], 2'b00};
            if (!w_diff[HW+2]) begin
                r_rem <= w_diff[HW+1:0];
                r_res <= {r_res[HW-2:0], 1'b1};
            end else begin
                r_rem <= w_cur;
                r_res <= {r_res[HW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[VW/2-1:0];
endmodule

// ===== hw/rtl/ucb1_arm_selector.sv =====
// ----------------------------------------------------------------------------
// ucb1_arm_selector
// UCB1 bandit arm selector with per-arm pull counts and reward sums.
// ----------------------------------------------------------------------------
// Input items on s_axis: tdata = {reward, arm}, tuser = opcode (0 observe,
// 1 clear). Each item yields one result item on m_axis: tdata = next_arm,
// tuser = chosen_unplayed. One item is processed at a time. When an unplayed
// arm exists the scan stops at the first one, which becomes the result.
// Otherwise a shared log unit runs once and then every arm in use passes
// through a bit-serial divider for the mean, the same divider for the
// exploration term and a bit-serial square root, then a compare with the best
// so far. The result register frees the input side: s_axis_tready rises
// again once the result is loaded, and a stalled receiver only holds the
// next result. Reset clears all statistics, sets arms_in_use to 8 and
// empties the result register. Write i_cfg_we only while idle.
// ----------------------------------------------------------------------------
`include "ucb1_arm_selector_defines.svh"

module ucb1_arm_selector #(
    parameter int ARM_COUNT   = ucb_pkg::ARM_COUNT_DEF,
    parameter int COUNT_WIDTH = ucb_pkg::COUNT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata,      // arms_in_use
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,     // [5:0] arm, [6] reward, [7] unused
    input  logic       s_axis_tuser,     // opcode
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,     // [5:0] next_arm, [7:6] zero
    output logic       m_axis_tuser      // chosen_unplayed
);
    localparam int AW   = (ARM_COUNT > 1) ? $clog2(ARM_COUNT) : 1;
    localparam int TW   = ucb_pkg::TOTAL_WIDTH;
    localparam int LW   = ucb_pkg::LN_W;
    localparam int MNW  = COUNT_WIDTH + 16;   // mean numerator
    localparam int ENW  = LW + 1 + 16;        // exploration numerator
    localparam int DNW  = (MNW > ENW) ? MNW : ENW;
    localparam int VW   = ucb_pkg::VAL_W;
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    typedef enum logic [3:0] {
        S_IDLE, S_UPD, S_SCAN, S_LN, S_LNW, S_ARM, S_DIVW, S_SQW, S_CMP, S_OUT
    } t_state;

    t_state r_state;
    logic [COUNT_WIDTH-1:0] r_cnt [ARM_COUNT];
    logic [COUNT_WIDTH-1:0] r_sum [ARM_COUNT];
    logic [TW-1:0]  r_total;
    logic [6:0]     r_arms;
    logic           r_op;
    logic [5:0]     r_arm_in;
    logic           r_rew;
    logic [AW-1:0]  r_i;
    logic [6:0]     r_act;
    logic [LW-1:0]  r_ln;
    logic [15:0]    r_mean;
    logic [VW-1:0]  r_best_val;
    logic [5:0]     r_best;
    logic           r_best_unp;
    logic           r_found;
    logic           r_mphase;
    logic           r_ovalid;
    logic [5:0]     r_oarm;
    logic           r_ounp;
    logic           r_div_go, r_sq_go, r_ln_go;
    logic [DNW-1:0] r_div_num;
    logic [COUNT_WIDTH-1:0] r_div_den;

    logic           w_div_busy, w_sq_busy, w_ln_busy;
    logic [DNW-1:0] w_quo;
    logic [DNW/2-1:0] w_root;
    logic [LW-1:0]  w_ln;
    logic [6:0]     w_act;
    logic [VW-1:0]  w_val;

    always_comb begin
        w_act = r_arms;
        if (r_arms == 7'd0) w_act = 7'd1;
        if (r_arms > 7'(ARM_COUNT)) w_act = 7'(ARM_COUNT);
    end

    assign w_val = VW'(r_mean) + VW'(w_root);

    ucb_div #(.NW(DNW), .DW(COUNT_WIDTH)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_num(r_div_num), .i_den(r_div_den), .o_busy(w_div_busy), .o_quo(w_quo)
    );
    ucb_sqrt #(.VW(DNW)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_sq_go),
        .i_v(w_quo), .o_busy(w_sq_busy), .o_root(w_root)
    );
    ucb_ln u_ln (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_ln_go),
        .i_x(r_total), .o_busy(w_ln_busy), .o_ln(w_ln)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_arms   <= 7'(ucb_pkg::ARMS_RESET);
            r_total  <= '0;
            r_div_go <= 1'b0;
            r_sq_go  <= 1'b0;
            r_ln_go  <= 1'b0;
            for (int k = 0; k < ARM_COUNT; k++) begin
                r_cnt[k] <= '0;
                r_sum[k] <= '0;
            end
        end else begin
            r_div_go <= 1'b0;
            r_sq_go  <= 1'b0;
            r_ln_go  <= 1'b0;
            if (i_cfg_we) r_arms <= i_cfg_wdata;
            if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op     <= s_axis_tuser;
                        r_arm_in <= s_axis_tdata[5:0];
                        r_rew    <= s_axis_tdata[6];
                        r_act    <= w_act;
                        r_state  <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (r_op == ucb_pkg::OP_CLEAR) begin
                        for (int k = 0; k < ARM_COUNT; k++) begin
                            r_cnt[k] <= '0;
                            r_sum[k] <= '0;
                        end
                        r_total <= '0;
                    end else if (7'(r_arm_in) < r_act
                                 && r_cnt[r_arm_in[AW-1:0]] != CMAX) begin
                        r_cnt[r_arm_in[AW-1:0]] <= r_cnt[r_arm_in[AW-1:0]] + 1'b1;
                        r_sum[r_arm_in[AW-1:0]] <= r_sum[r_arm_in[AW-1:0]]
                                                   + COUNT_WIDTH'(r_rew);
                        if (r_total != '1) r_total <= r_total + 1'b1;
                    end
                    r_i     <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // Walk arms in order looking for one never pulled.
                    if (r_cnt[r_i] == '0) begin
                        r_best     <= 6'(r_i);
                        r_best_unp <= 1'b1;
                        r_state    <= S_OUT;
                    end else if (7'(r_i) + 7'd1 >= r_act) begin
                        r_ln_go <= 1'b1;
                        r_state <= S_LN;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_LN: r_state <= S_LNW;
                S_LNW: begin
                    if (!w_ln_busy) begin
                        r_ln    <= w_ln;
                        r_i     <= '0;
                        r_found <= 1'b0;
                        r_state <= S_ARM;
                    end
                end
                S_ARM: begin
                    r_div_num <= DNW'({r_sum[r_i], 16'd0});
                    r_div_den <= r_cnt[r_i];
                    r_div_go  <= 1'b1;
                    r_mphase  <= 1'b1;
                    r_state   <= S_DIVW;
                end
                S_DIVW: begin
                    if (!r_div_go && !w_div_busy) begin
                        if (r_mphase) begin
                            r_mean    <= (w_quo > DNW'(16'hFFFF)) ? 16'hFFFF : w_quo[15:0];
                            r_div_num <= DNW'({r_ln, 17'd0});
                            r_div_go  <= 1'b1;
                            r_mphase  <= 1'b0;
                        end else begin
                            r_sq_go <= 1'b1;
                            r_state <= S_SQW;
                        end
                    end
                end
                S_SQW: begin
                    if (!r_sq_go && !w_sq_busy) r_state <= S_CMP;
                end
                S_CMP: begin
                    if (!r_found || w_val > r_best_val) begin
                        r_found    <= 1'b1;
                        r_best_val <= w_val;
                        r_best     <= 6'(r_i);
                    end
                    if (7'(r_i) + 7'd1 >= r_act) begin
                        r_best_unp <= 1'b0;
                        r_state    <= S_OUT;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_ARM;
                    end
                end
                S_OUT: begin
                    // The held result may only change once it has left.
                    if (!r_ovalid || m_axis_tready) begin
                        r_oarm  <= r_best;
                        r_ounp  <= r_best_unp;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_oarm};
    assign m_axis_tuser  = r_ounp;

    `UCB_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, r_state == S_UPD)
    `UCB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `UCB_ASSERT_IMP(a_arm_range, i_clk, i_rst_n,
        m_axis_tvalid, 7'(m_axis_tdata[5:0]) < 7'(ARM_COUNT))
    `UCB_ASSERT_IMP(a_units_exclusive, i_clk, i_rst_n,
        1'b1, !(w_div_busy && w_sq_busy))
endmodule
